FILE: src/cfba_pkg.sv
// ----------------------------------------------------------------------------
// cfba_pkg
// shared types, codes and defaults of the chained free block allocator
// ----------------------------------------------------------------------------
package cfba_pkg;

	localparam int unsigned WINDOW_DEPTH_DEF = 32;
	localparam int unsigned BN_BITS_DEF      = 32;
	localparam int unsigned WORD_W           = 32;
	localparam int unsigned WIDX_W           = 6;
	localparam int unsigned QUEUE_DEPTH      = 2;
	localparam int unsigned CFG_IDX_W        = 1;

	localparam logic [WORD_W-1:0] FIRST_RESET = 32'd64;
	localparam logic [WORD_W-1:0] TOTAL_RESET = 32'd4096;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_FIRST_DATA = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_TOTAL      = 1'b1;

	typedef enum logic [1:0] {
		OP_FORMAT = 2'd0,
		OP_ALLOC  = 2'd1,
		OP_FREE   = 2'd2,
		OP_CHAIN  = 2'd3
	} op_t;

	typedef enum logic [3:0] {
		K_GRANTED    = 4'd0,
		K_NO_FREE    = 4'd1,
		K_EXHAUSTED  = 4'd2,
		K_BUSY       = 4'd3,
		K_FREED      = 4'd4,
		K_COUNTED    = 4'd5,
		K_REJECTED   = 4'd6,
		K_SPILL      = 4'd7,
		K_CHAIN_READ = 4'd8,
		K_FORMATTED  = 4'd9,
		K_IGNORED    = 4'd10
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FMT,
		ST_AL_EMIT,
		ST_SP_RD,
		ST_SP_EMIT,
		ST_SP_TERM,
		ST_EMIT
	} state_t;

	// classified command handed from front to back
	typedef struct packed {
		op_t               op;
		logic [WORD_W-1:0] bn;
		logic              reject;
	} cmd_t;

	typedef struct packed {
		kind_t             kind;
		logic [WORD_W-1:0] bn;
		logic [WIDX_W-1:0] idx;
		logic [WORD_W-1:0] val;
		logic              last;
	} res_t;

endpackage

FILE: src/chained_free_block_allocator.sv
// ----------------------------------------------------------------------------
// chained_free_block_allocator
// free block allocator with an on-chip window stack and an overflow chain
// ----------------------------------------------------------------------------
// usage:
//   input transactions carry an op in s_tuser (format, allocate, free, chain
//   word) and a block number or chain word in s_tdata
//   each transaction, but a chain word that continues a refill, gives
//   results on the m channel: kind in m_tuser, block, word index and word
//   value in m_tdata, m_tlast on the final result; a free into a full
//   window streams the window plus a zero terminator as spill words into
//   the freed block; an allocate that empties the window while more than
//   one block is free asks for a chain read, and chain words then refill
//   it; a transaction passes the command queue, the back end's dispatch
//   and emit states and the output register; the back end takes one at a
//   time; a spill reads and emits each window word, then the terminator;
//   format writes one window entry per cycle, up to WINDOW_DEPTH, before its result
//   a two-entry command queue takes transactions while the back end works
//   or m_tready is low; s_tready drops when it is full and for the first
//   cycle after reset; results wait in the output register while stalled
//   reset clears the window count, free count and refill flag; config
//   registers return to first block 64 and 4096 total blocks
//   cfg_we writes cfg_data into the register selected by cfg_index
// ----------------------------------------------------------------------------
module chained_free_block_allocator
	import cfba_pkg::*;
#(
	parameter int unsigned WINDOW_DEPTH      = WINDOW_DEPTH_DEF,
	parameter int unsigned BLOCK_NUMBER_BITS = BN_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// input channel
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [WORD_W-1:0]    s_tdata,   // block_number
	input  logic [1:0]           s_tuser,   // op
	// result channel
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [71:0]          m_tdata,   // block_number_res, word_index, word_value
	output logic [3:0]           m_tuser,   // kind
	output logic                 m_tlast,
	// configuration write port
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [WORD_W-1:0]    cfg_data
);

	logic [WORD_W-1:0] first_q;
	logic [WORD_W-1:0] total_q;

	logic q_full, q_push, q_valid, q_pop;
	cmd_t push_cmd, head_cmd;
	res_t res;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q <= FIRST_RESET;
			total_q <= TOTAL_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_FIRST_DATA: first_q <= cfg_data;
				CFG_TOTAL:      total_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// front: accept and classify
	cfba_front #(
		.BLOCK_NUMBER_BITS(BLOCK_NUMBER_BITS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.first_block (first_q),
		.total_blocks(total_q),
		.q_full      (q_full),
		.q_push      (q_push),
		.q_cmd       (push_cmd)
	);

	// command queue between the two halves
	cfba_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_cmd  (push_cmd),
		.full      (q_full),
		.pop       (q_pop),
		.head_valid(q_valid),
		.head_cmd  (head_cmd)
	);

	// back: window memory, counters and result register
	cfba_back #(
		.WINDOW_DEPTH(WINDOW_DEPTH)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.first_block (first_q),
		.total_blocks(total_q),
		.q_valid     (q_valid),
		.q_cmd       (head_cmd),
		.q_pop       (q_pop),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.out_res     (res)
	);

	// pack the result transaction
	assign m_tdata = {2'b00, res.val, res.idx, res.bn};
	assign m_tuser = res.kind;
	assign m_tlast = res.last;

endmodule

FILE: src/cfba_front.sv
// ----------------------------------------------------------------------------
// cfba_front
// accepts input transactions, masks the block number and range-checks frees
// ----------------------------------------------------------------------------
module cfba_front
	import cfba_pkg::*;
#(
	parameter int unsigned BLOCK_NUMBER_BITS = BN_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [WORD_W-1:0] s_tdata,
	input  logic [1:0]        s_tuser,
	input  logic [WORD_W-1:0] first_block,
	input  logic [WORD_W-1:0] total_blocks,
	input  logic              q_full,
	output logic              q_push,
	output cmd_t              q_cmd
);

	localparam logic [WORD_W-1:0] BN_MASK = {WORD_W{1'b1}} >> (WORD_W - BLOCK_NUMBER_BITS);

	logic [WORD_W-1:0] bn;
	logic              busy_q;

	// hold off until busy_q clears after reset release
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
		end else begin
			busy_q <= 1'b0;
		end
	end

	assign bn       = s_tdata & BN_MASK;
	assign s_tready = !q_full && !busy_q;
	assign q_push   = s_tvalid && s_tready;

	always_comb begin
		q_cmd.op     = op_t'(s_tuser);
		q_cmd.bn     = bn;
		q_cmd.reject = (op_t'(s_tuser) == OP_FREE) && ((bn < first_block) || (bn >= total_blocks));
	end

endmodule

FILE: src/cfba_queue.sv
// ----------------------------------------------------------------------------
// cfba_queue
// short command queue between front and back
// ----------------------------------------------------------------------------
module cfba_queue
	import cfba_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	input  logic pop,
	output logic head_valid,
	output cmd_t head_cmd
);

	localparam int unsigned QAW = $clog2(QUEUE_DEPTH);
	localparam int unsigned QCW = $clog2(QUEUE_DEPTH + 1);

	cmd_t           ent_q [QUEUE_DEPTH];
	logic [QAW-1:0] wptr_q;
	logic [QAW-1:0] rptr_q;
	logic [QCW-1:0] count_q;

	assign full       = count_q == QCW'(QUEUE_DEPTH);
	assign head_valid = count_q != '0;
	assign head_cmd   = ent_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= rptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

FILE: src/cfba_back.sv
// ----------------------------------------------------------------------------
// cfba_back
// executes commands against the window memory and drives the result register
// ----------------------------------------------------------------------------
module cfba_back
	import cfba_pkg::*;
#(
	parameter int unsigned WINDOW_DEPTH = WINDOW_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [WORD_W-1:0] first_block,
	input  logic [WORD_W-1:0] total_blocks,
	input  logic              q_valid,
	input  cmd_t              q_cmd,
	output logic              q_pop,
	output logic              out_valid,
	input  logic              out_ready,
	output res_t              out_res
);

	localparam int unsigned AW = $clog2(WINDOW_DEPTH);
	localparam int unsigned FW = $clog2(WINDOW_DEPTH + 1);
	localparam logic [FW-1:0] WD_F  = FW'(WINDOW_DEPTH);
	localparam logic [FW-1:0] WD_M1 = FW'(WINDOW_DEPTH - 1);

	state_t            state_q, state_d;
	logic [FW-1:0]     fill_q;
	logic [WORD_W-1:0] free_q;
	logic              refill_q;
	logic [WORD_W-1:0] pend_q;
	logic [FW-1:0]     wt_q;
	logic [FW-1:0]     cnt_q;
	logic [WORD_W-1:0] bn_q;
	res_t              res_q;
	res_t              res_d;
	logic              out_valid_q;
	res_t              out_q;

	logic [WORD_W-1:0] mem [WINDOW_DEPTH];
	logic [WORD_W-1:0] rd_q;
	logic              mem_we, mem_re;
	logic [AW-1:0]     mem_wa, mem_ra;
	logic [WORD_W-1:0] mem_wd;

	logic              out_free;
	logic              emit_valid;
	res_t              emit_res;

	logic [FW-1:0]     fill_m1;
	logic [FW-1:0]     wt_inc;
	logic              alloc_go;
	logic              win_full;
	logic              chain_store;
	logic              chain_more;
	logic              fmt_write;
	logic [WORD_W-1:0] fmt_free;
	logic              to_chain;

	assign out_free    = !out_valid_q || out_ready;
	assign fill_m1     = fill_q - 1'b1;
	assign wt_inc      = wt_q + 1'b1;
	assign alloc_go    = !refill_q && (free_q != '0) && (fill_q != '0);
	assign win_full    = fill_q == WD_F;
	assign chain_store = (q_cmd.bn != '0) && (wt_q != WD_F);
	assign chain_more  = chain_store && (wt_inc != WD_F);
	assign fmt_write   = (cnt_q != WD_F) && ({{(WORD_W-FW){1'b0}}, cnt_q} < free_q);
	assign fmt_free    = (total_blocks > first_block) ? (total_blocks - first_block) : '0;
	assign to_chain    = (fill_q == '0) && (free_q > 32'd1);

	// single-result answers decided at dispatch
	always_comb begin
		res_d = '{kind: K_IGNORED, bn: '0, idx: '0, val: '0, last: 1'b1};
		case (q_cmd.op)
			OP_FORMAT: begin
				res_d.kind = K_FORMATTED;
			end
			OP_ALLOC: begin
				if (refill_q) begin
					res_d.kind = K_BUSY;
				end else if (free_q == '0) begin
					res_d.kind = K_NO_FREE;
				end else begin
					res_d.kind = K_EXHAUSTED;
				end
			end
			OP_FREE: begin
				res_d.bn = q_cmd.bn;
				if (q_cmd.reject) begin
					res_d.kind = K_REJECTED;
				end else if (refill_q) begin
					res_d.kind = K_COUNTED;
				end else begin
					res_d.kind = K_FREED;
				end
			end
			OP_CHAIN: begin
				if (refill_q) begin
					res_d.kind = K_GRANTED;
					res_d.bn   = pend_q;
				end
			end
			default: ;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (q_valid) begin
					case (q_cmd.op)
						OP_FORMAT: state_d = ST_FMT;
						OP_ALLOC:  state_d = alloc_go ? ST_AL_EMIT : ST_EMIT;
						OP_FREE: begin
							if (!q_cmd.reject && !refill_q && win_full) begin
								state_d = ST_SP_RD;
							end else begin
								state_d = ST_EMIT;
							end
						end
						OP_CHAIN: begin
							state_d = (refill_q && chain_more) ? ST_IDLE : ST_EMIT;
						end
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_FMT: begin
				if (!fmt_write && out_free) begin
					state_d = ST_IDLE;
				end
			end
			ST_AL_EMIT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			ST_SP_RD: begin
				state_d = ST_SP_EMIT;
			end
			ST_SP_EMIT: begin
				if (out_free) begin
					state_d = (cnt_q == WD_M1) ? ST_SP_TERM : ST_SP_RD;
				end
			end
			ST_SP_TERM: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// memory controls, queue pop and result emission
	always_comb begin
		q_pop      = 1'b0;
		mem_we     = 1'b0;
		mem_wa     = '0;
		mem_wd     = q_cmd.bn;
		mem_re     = 1'b0;
		mem_ra     = '0;
		emit_valid = 1'b0;
		emit_res   = res_q;
		case (state_q)
			ST_IDLE: begin
				if (q_valid) begin
					q_pop = 1'b1;
					case (q_cmd.op)
						OP_ALLOC: begin
							mem_re = alloc_go;
							mem_ra = fill_m1[AW-1:0];
						end
						OP_FREE: begin
							mem_we = !q_cmd.reject && !refill_q && !win_full;
							mem_wa = fill_q[AW-1:0];
						end
						OP_CHAIN: begin
							mem_we = refill_q && chain_store;
							mem_wa = wt_q[AW-1:0];
						end
						default: ;
					endcase
				end
			end
			ST_FMT: begin
				mem_we     = fmt_write;
				mem_wa     = cnt_q[AW-1:0];
				mem_wd     = first_block + {{(WORD_W-FW){1'b0}}, cnt_q};
				emit_valid = !fmt_write;
				emit_res   = '{kind: K_FORMATTED, bn: '0, idx: '0, val: '0, last: 1'b1};
			end
			ST_AL_EMIT: begin
				emit_valid = 1'b1;
				emit_res   = '{kind: (to_chain ? K_CHAIN_READ : K_GRANTED), bn: rd_q,
					idx: '0, val: '0, last: 1'b1};
			end
			ST_SP_RD: begin
				mem_re = 1'b1;
				mem_ra = cnt_q[AW-1:0];
			end
			ST_SP_EMIT: begin
				emit_valid = 1'b1;
				emit_res   = '{kind: K_SPILL, bn: bn_q, idx: WIDX_W'(cnt_q), val: rd_q,
					last: 1'b0};
			end
			ST_SP_TERM: begin
				emit_valid = 1'b1;
				emit_res   = '{kind: K_SPILL, bn: bn_q, idx: WIDX_W'(WD_F), val: '0,
					last: 1'b1};
				mem_we     = out_free;
				mem_wa     = '0;
				mem_wd     = bn_q;
			end
			ST_EMIT: begin
				emit_valid = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (mem_re) begin
			rd_q <= mem[mem_ra];
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && q_valid) begin
			res_q <= res_d;
			bn_q  <= q_cmd.bn;
		end
		if (out_free && emit_valid) begin
			out_q <= emit_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			fill_q      <= '0;
			free_q      <= '0;
			refill_q    <= 1'b0;
			pend_q      <= '0;
			wt_q        <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_free) begin
				out_valid_q <= emit_valid;
			end
			case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						case (q_cmd.op)
							OP_FORMAT: begin
								free_q   <= fmt_free;
								refill_q <= 1'b0;
								pend_q   <= '0;
								wt_q     <= '0;
								cnt_q    <= '0;
							end
							OP_ALLOC: begin
								if (alloc_go) begin
									fill_q <= fill_m1;
								end
							end
							OP_FREE: begin
								if (!q_cmd.reject) begin
									if (free_q != '1) begin
										free_q <= free_q + 1'b1;
									end
									if (!refill_q) begin
										if (win_full) begin
											cnt_q <= '0;
										end else begin
											fill_q <= fill_q + 1'b1;
										end
									end
								end
							end
							OP_CHAIN: begin
								if (refill_q) begin
									if (chain_store) begin
										wt_q <= wt_inc;
									end
									if (!chain_more) begin
										fill_q   <= chain_store ? wt_inc : wt_q;
										refill_q <= 1'b0;
										if (free_q != '0) begin
											free_q <= free_q - 1'b1;
										end
									end
								end
							end
							default: ;
						endcase
					end
				end
				ST_FMT: begin
					if (fmt_write) begin
						cnt_q <= cnt_q + 1'b1;
					end else begin
						fill_q <= cnt_q;
					end
				end
				ST_AL_EMIT: begin
					if (out_free) begin
						if (to_chain) begin
							refill_q <= 1'b1;
							pend_q   <= rd_q;
							wt_q     <= '0;
						end else begin
							free_q <= free_q - 1'b1;
						end
					end
				end
				ST_SP_EMIT: begin
					if (out_free) begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_SP_TERM: begin
					if (out_free) begin
						fill_q <= FW'(1);
					end
				end
				default: ;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_res   = out_q;

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the chained free block allocator
// ----------------------------------------------------------------------------
// a shadow copy of the window stack, free count and refill state predicts
// every result of each accepted transaction; a checker compares the result
// stream field by field in order. directed tasks hit the corner cases
// (unformatted volume, spill, refill, busy, counted-only frees, saturation,
// empty and extreme volumes), then random phases under several volume
// settings drive well-formed alloc/free/refill traffic with some noise and
// random idling on both sides; a backpressure test adds one long output stall
// ----------------------------------------------------------------------------
module tb;
	import cfba_pkg::*;

	localparam int unsigned DEPTH         = WINDOW_DEPTH_DEF;
	localparam int unsigned WIN_AW        = $clog2(DEPTH);
	localparam int unsigned SETTLE_CYCLES = 80;
	localparam int unsigned HOLD_CYCLES   = 400;
	localparam int unsigned CYCLE_LIMIT   = 4_000_000;
	localparam int unsigned PRINT_LIMIT   = 40;

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [WORD_W-1:0]    s_tdata;   // block_number
	logic [1:0]           s_tuser;   // op
	logic                 m_tvalid;
	logic                 m_tready;
	logic [71:0]          m_tdata;   // block_number_res, word_index, word_value
	logic [3:0]           m_tuser;   // kind
	logic                 m_tlast;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [WORD_W-1:0]    cfg_data;

	chained_free_block_allocator uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// ------------------------------------------------------------------------
	// shadow allocator state, updated as each transaction is accepted
	// ------------------------------------------------------------------------
	logic [WORD_W-1:0] win [0:DEPTH-1];
	int unsigned       win_fill   = 0;
	logic [WORD_W-1:0] free_cnt   = '0;
	bit                refill_on  = 1'b0;
	logic [WORD_W-1:0] grant_blk  = '0;
	int unsigned       chain_cnt  = 0;
	logic [WORD_W-1:0] cfg_first  = FIRST_RESET;
	logic [WORD_W-1:0] cfg_total  = TOTAL_RESET;

	// results still owed by the block, oldest first
	res_t owed_results [$];

	int unsigned errors     = 0;
	int unsigned n_sent     = 0;
	int unsigned n_results  = 0;
	int unsigned n_spills   = 0;
	int unsigned n_refills  = 0;
	int unsigned cycles     = 0;

	// idling controls for the sender and the ready process
	bit tx_steady = 1'b0;
	bit rx_steady = 1'b0;
	bit hold_req  = 1'b0;

	// ------------------------------------------------------------------------
	// clock and watchdog
	// ------------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still owed", cycles,
				owed_results.size());
			$display("Regression FAIL");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// prediction
	// ------------------------------------------------------------------------
	function automatic void owe(input kind_t k, input logic [WORD_W-1:0] b,
			input logic [WIDX_W-1:0] i, input logic [WORD_W-1:0] v, input logic l);
		res_t r;
		r.kind = k;
		r.bn   = b;
		r.idx  = i;
		r.val  = v;
		r.last = l;
		owed_results.push_back(r);
	endfunction

	// advance the shadow allocator by one transaction and queue its results
	function automatic void apply_command(input op_t op, input logic [WORD_W-1:0] bn);
		logic [WORD_W:0]   b;
		logic [WORD_W-1:0] top;
		bit                done;
		case (op)
			OP_FORMAT: begin
				// load the window with the first run of data blocks
				b = {1'b0, cfg_first};
				win_fill = 0;
				while (b < {1'b0, cfg_total} && win_fill < DEPTH) begin
					win[WIN_AW'(win_fill)] = b[WORD_W-1:0];
					win_fill++;
					b++;
				end
				free_cnt  = (cfg_total > cfg_first) ? cfg_total - cfg_first : '0;
				refill_on = 1'b0;
				grant_blk = '0;
				chain_cnt = 0;
				owe(K_FORMATTED, '0, '0, '0, 1'b1);
			end
			OP_ALLOC: begin
				if (refill_on)
					owe(K_BUSY, '0, '0, '0, 1'b1);
				else if (free_cnt == 0)
					owe(K_NO_FREE, '0, '0, '0, 1'b1);
				else if (win_fill == 0)
					owe(K_EXHAUSTED, '0, '0, '0, 1'b1);
				else begin
					win_fill--;
					top = win[WIN_AW'(win_fill)];
					if (win_fill == 0 && free_cnt > 1) begin
						// last cached entry names the next chain block
						refill_on = 1'b1;
						grant_blk = top;
						chain_cnt = 0;
						n_refills++;
						owe(K_CHAIN_READ, top, '0, '0, 1'b1);
					end else begin
						free_cnt--;
						owe(K_GRANTED, top, '0, '0, 1'b1);
					end
				end
			end
			OP_FREE: begin
				if (bn < cfg_first || bn >= cfg_total)
					owe(K_REJECTED, bn, '0, '0, 1'b1);
				else begin
					if (free_cnt != '1)
						free_cnt++;
					if (refill_on)
						owe(K_COUNTED, bn, '0, '0, 1'b1);
					else if (win_fill >= DEPTH) begin
						// whole window plus terminator go into the freed block
						for (int i = 0; i < DEPTH; i++)
							owe(K_SPILL, bn, WIDX_W'(i), win[WIN_AW'(i)], 1'b0);
						owe(K_SPILL, bn, WIDX_W'(DEPTH), '0, 1'b1);
						win[0]   = bn;
						win_fill = 1;
						n_spills++;
					end else begin
						win[WIN_AW'(win_fill)] = bn;
						win_fill++;
						owe(K_FREED, bn, '0, '0, 1'b1);
					end
				end
			end
			OP_CHAIN: begin
				if (!refill_on)
					owe(K_IGNORED, '0, '0, '0, 1'b1);
				else begin
					done = 1'b1;
					if (bn != 0 && chain_cnt < DEPTH) begin
						win[WIN_AW'(chain_cnt)] = bn;
						chain_cnt++;
						if (chain_cnt < DEPTH)
							done = 1'b0;
					end
					// zero word or a full window ends the refill
					if (done) begin
						win_fill  = chain_cnt;
						refill_on = 1'b0;
						if (free_cnt != 0)
							free_cnt--;
						owe(K_GRANTED, grant_blk, '0, '0, 1'b1);
					end
				end
			end
		endcase
	endfunction

	// ------------------------------------------------------------------------
	// result checking
	// ------------------------------------------------------------------------
	task automatic report_mismatch(input string what, input logic [WORD_W-1:0] got,
			input logic [WORD_W-1:0] want_v);
		errors++;
		if (errors <= PRINT_LIMIT)
			$display("mismatch on %s at result %0d: got %h, expected %h", what,
				n_results, got, want_v);
	endtask

	always @(posedge clk) begin : check_results
		res_t want;
		if (arst_n && m_tvalid && m_tready) begin
			n_results++;
			if (owed_results.size() == 0)
				report_mismatch("unowed result kind", WORD_W'(m_tuser), '0);
			else begin
				want = owed_results.pop_front();
				if (m_tuser !== want.kind)
					report_mismatch("kind", WORD_W'(m_tuser), WORD_W'(want.kind));
				if (m_tdata[31:0] !== want.bn)
					report_mismatch("block_number_res", m_tdata[31:0], want.bn);
				if (m_tdata[37:32] !== want.idx)
					report_mismatch("word_index", WORD_W'(m_tdata[37:32]),
						WORD_W'(want.idx));
				if (m_tdata[69:38] !== want.val)
					report_mismatch("word_value", m_tdata[69:38], want.val);
				if (m_tlast !== want.last)
					report_mismatch("last", WORD_W'(m_tlast), WORD_W'(want.last));
			end
		end
	end

	// ------------------------------------------------------------------------
	// receiver: random stalls, steady stretches and one long hold-off
	// ------------------------------------------------------------------------
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 92)
			return $urandom_range(1, 3);
		else
			return $urandom_range(10, 40);
	endfunction

	initial begin : ready_gen
		m_tready <= 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				// long hold so the output register and command queue fill up
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else if (rx_steady || $urandom_range(0, 2) != 0) begin
				m_tready <= 1'b1;
				repeat ($urandom_range(1, 20)) @(posedge clk);
			end else begin
				m_tready <= 1'b0;
				repeat (pick_gap() + 1) @(posedge clk);
			end
		end
	end

	// ------------------------------------------------------------------------
	// sender and configuration helpers
	// ------------------------------------------------------------------------
	// offer one transaction, keeping tvalid high when there is no gap
	task automatic send_item(input op_t op, input logic [WORD_W-1:0] bn);
		int gap;
		gap = tx_steady ? 0 : pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= bn;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		apply_command(op, bn);
		n_sent++;
	endtask

	// stop offering, wait for every owed result, then let the block go quiet
	task automatic settle();
		s_tvalid <= 1'b0;
		while (owed_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] v);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		if (idx == CFG_FIRST_DATA)
			cfg_first = v;
		else if (idx == CFG_TOTAL)
			cfg_total = v;
	endtask

	// block for a free: mostly inside the volume, some just outside it
	function automatic logic [WORD_W-1:0] pick_block();
		logic [WORD_W-1:0] b;
		int r;
		r = $urandom_range(0, 99);
		if (r < 85 && cfg_total > cfg_first)
			b = $urandom_range(cfg_total - 1, cfg_first);
		else if (r < 90 && cfg_first != 0)
			b = cfg_first - 1;
		else if (r < 95)
			b = cfg_total;
		else
			b = $urandom;
		return b;
	endfunction

	// ------------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------------
	// volume never formatted: nothing free, stray chain word, range checks
	task automatic test_unformatted();
		send_item(OP_ALLOC, '0);
		send_item(OP_CHAIN, 32'h0000_0005);
		send_item(OP_FREE, FIRST_RESET - 1);
		send_item(OP_FREE, TOTAL_RESET);
		send_item(OP_FREE, FIRST_RESET);
		send_item(OP_ALLOC, '0);
		send_item(OP_ALLOC, '0);
	endtask

	// spill of a full window, refill with busy and counted-only frees,
	// empty window with blocks still counted, format cancelling a refill
	task automatic test_spill_and_refill();
		send_item(OP_FORMAT, '0);
		send_item(OP_FREE, 32'd100);
		send_item(OP_ALLOC, '0);
		send_item(OP_ALLOC, '0);
		send_item(OP_FREE, TOTAL_RESET - 1);
		send_item(OP_FREE, TOTAL_RESET);
		send_item(OP_CHAIN, 32'hFFFF_FFFF);
		send_item(OP_CHAIN, '0);
		send_item(OP_ALLOC, '0);
		send_item(OP_CHAIN, '0);
		send_item(OP_ALLOC, '0);
		send_item(OP_FREE, 32'd300);
		send_item(OP_ALLOC, '0);
		send_item(OP_FORMAT, '1);
		send_item(OP_ALLOC, '0);
	endtask

	// widest volume with a saturated count, an empty volume, a one-block volume
	task automatic test_extreme_config();
		settle();
		write_cfg(CFG_FIRST_DATA, '0);
		write_cfg(CFG_TOTAL, '1);
		send_item(OP_FORMAT, '0);
		send_item(OP_FREE, 32'hFFFF_FFFE);
		send_item(OP_FREE, 32'hFFFF_FFFF);
		send_item(OP_FREE, '0);
		settle();
		write_cfg(CFG_FIRST_DATA, '1);
		write_cfg(CFG_TOTAL, '0);
		send_item(OP_FORMAT, '0);
		send_item(OP_ALLOC, '0);
		send_item(OP_FREE, '0);
		settle();
		write_cfg(CFG_FIRST_DATA, 32'd5);
		write_cfg(CFG_TOTAL, 32'd6);
		send_item(OP_FORMAT, '0);
		send_item(OP_ALLOC, '0);
		send_item(OP_ALLOC, '0);
	endtask

	// receiver holds off while the sender keeps offering back to back
	task automatic test_backpressure();
		settle();
		write_cfg(CFG_FIRST_DATA, FIRST_RESET);
		write_cfg(CFG_TOTAL, TOTAL_RESET);
		tx_steady = 1'b1;
		hold_req  = 1'b1;
		send_item(OP_FORMAT, '0);
		for (int k = 0; k < 30; k++) begin
			if (k % 3 == 2)
				send_item(OP_ALLOC, '0);
			else
				send_item(OP_FREE, $urandom_range(TOTAL_RESET - 1, FIRST_RESET));
		end
		tx_steady = 1'b0;
	endtask

	// one random phase: format, then mostly well-formed alloc/free/refill
	// traffic, with stray chain words, out-of-range frees and reformats
	task automatic test_random_phase(input logic [WORD_W-1:0] first,
			input logic [WORD_W-1:0] total, input int n, input bit steady);
		int                r;
		int                chain_left;
		bit                refill_seen;
		logic [WORD_W-1:0] w;
		settle();
		write_cfg(CFG_FIRST_DATA, first);
		write_cfg(CFG_TOTAL, total);
		tx_steady   = steady;
		rx_steady   = steady;
		chain_left  = 0;
		refill_seen = 1'b0;
		send_item(OP_FORMAT, $urandom);
		repeat (n) begin
			r = $urandom_range(0, 99);
			// a new refill decides how many chain words the chain block holds
			if (refill_on && !refill_seen) begin
				refill_seen = 1'b1;
				chain_left  = ($urandom_range(0, 5) == 0) ? DEPTH : $urandom_range(0, 6);
			end
			if (!refill_on)
				refill_seen = 1'b0;
			if (refill_on) begin
				if (r < 80) begin
					if (chain_left > 0) begin
						w = $urandom;
						if (w == 0)
							w = 1;
						chain_left--;
					end else
						w = '0;
					send_item(OP_CHAIN, w);
				end else if (r < 88)
					send_item(OP_ALLOC, $urandom);
				else if (r < 97)
					send_item(OP_FREE, pick_block());
				else
					send_item(OP_FORMAT, $urandom);
			end else begin
				if (r < 3)
					send_item(OP_FORMAT, $urandom);
				else if (r < 45)
					send_item(OP_ALLOC, $urandom);
				else if (r < 92)
					send_item(OP_FREE, pick_block());
				else
					send_item(OP_CHAIN, $urandom);
			end
		end
		tx_steady = 1'b0;
		rx_steady = 1'b0;
	endtask

	// several volume settings, small and large, one without idling
	task automatic test_random_mix();
		logic [WORD_W-1:0] f;
		test_random_phase(FIRST_RESET, TOTAL_RESET, 80, 1'b0);
		f = $urandom_range(0, 1000);
		test_random_phase(f, f + $urandom_range(2, 40), 70, 1'b0);
		test_random_phase('0, '1, 70, 1'b0);
		f = $urandom_range(0, 32'h7FFF_0000);
		test_random_phase(f, f + $urandom_range(33, 3000), 60, 1'b1);
		f = $urandom_range(0, 32'hFFFF_0000);
		test_random_phase(f, f + $urandom_range(1, 3), 50, 1'b0);
	endtask

	// ------------------------------------------------------------------------
	// sequence
	// ------------------------------------------------------------------------
	initial begin : run
		arst_n    <= 1'b0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		s_tuser   <= OP_FORMAT;
		cfg_we    <= 1'b0;
		cfg_index <= CFG_FIRST_DATA;
		cfg_data  <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_unformatted();
		test_spill_and_refill();
		test_extreme_config();
		test_backpressure();
		test_random_mix();
		settle();

		$display("covered %0d input transactions and %0d results across several volume settings",
			n_sent, n_results);
		$display("including %0d window spills, %0d chain refills, %0d mismatches",
			n_spills, n_refills, errors);
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
